// ===== design/fprc8_pkg.sv =====
// Package for the framed packet receiver: beat types, opcode and event codes,
// packet limits and the CRC-8 (poly 0x07) byte update. No dependencies.
package fprc8_pkg;

  localparam int unsigned MaxPayload  = 11;
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned StoreDepth  = 16;
  localparam int unsigned PosW        = $clog2(StoreDepth);

  localparam logic [7:0] PreambleByte = 8'h55;
  localparam logic [7:0] SyncByte     = 8'hF0;
  localparam logic [7:0] CrcPoly      = 8'h07;

  typedef enum logic [2:0] {
    OP_RX      = 3'd0,
    OP_TAKE    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_READ    = 3'd3,
    OP_RESET   = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PREAMBLE = 3'd1,
    EV_HEADER   = 3'd2,
    EV_PAYLOAD  = 3'd3,
    EV_ACCEPT   = 3'd4,
    EV_CRC_BAD  = 3'd5,
    EV_LEN_BAD  = 3'd6,
    EV_BUSY     = 3'd7
  } event_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [3:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] byte_position;
    logic [7:0] read_data;
    logic       packet_ready;
    logic       buffer_held;
    logic       active;
  } out_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] byte_position;
    logic       packet_ready;
    logic       buffer_held;
    logic       active;
  } parse_res_t;

  typedef struct packed {
    logic            we;
    logic [PosW-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [PosW-1:0] raddr;
  } store_req_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/fprc8_store.sv =====
// Single packet buffer: 16 x 8 memory, one write and one registered read per beat.
// Depends on fprc8_pkg.
module fprc8_store
  import fprc8_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  store_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [StoreDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (req_i.we) begin
        mem[req_i.waddr] <= req_i.wdata;
      end
      rdata_q <= req_i.re ? mem[req_i.raddr] : 8'h00;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fprc8_parser.sv =====
// Deframer state machine: preamble/sync hunt, header and payload capture,
// CRC-8 check and client opcodes. Depends on fprc8_pkg.
module fprc8_parser
  import fprc8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_item_t   item_i,
  output parse_res_t res_o,
  output store_req_t req_o
);

  localparam logic [2:0] PhSearch = 3'd0;
  localparam logic [2:0] PhSync   = 3'd1;
  localparam logic [2:0] PhHeader = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhCheck  = 3'd4;

  localparam logic [PosW-1:0] LastHdrPos = PosW'(HeaderBytes - 1);
  localparam logic [7:0]      MaxLen     = 8'(MaxPayload);

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      crc_q, crc_d;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic [7:0]      remain_q, remain_d;
  logic            held_q, held_d;
  logic            ready_q, ready_d, ready_mid;
  logic [2:0]      ev;
  logic [PosW-1:0] pos;
  logic [7:0]      b;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    wpos_d    = wpos_q;
    remain_d  = remain_q;
    held_d    = held_q;
    ready_mid = ready_q;
    ev        = EV_NONE;
    pos       = '0;
    req_o     = '{we: 1'b0, waddr: wpos_q, wdata: b, re: 1'b0, raddr: item_i.read_index};

    unique case (item_i.opcode)
      OP_RX: begin
        unique case (phase_q)
          PhSearch: begin
            if (b == PreambleByte) begin
              phase_d = PhSync;
              ev      = EV_PREAMBLE;
            end
          end
          PhSync: begin
            if (b == SyncByte) begin
              if (!held_q) begin
                held_d  = 1'b1;
                phase_d = PhHeader;
                wpos_d  = '0;
                crc_d   = 8'h00;
              end else begin
                phase_d = PhSearch;
                ev      = EV_BUSY;
              end
            end else if (b == PreambleByte) begin
              ev = EV_PREAMBLE;
            end else begin
              phase_d = PhSearch;
            end
          end
          PhHeader: begin
            pos      = wpos_q;
            req_o.we = 1'b1;
            crc_d    = crc8_update(crc_q, b);
            wpos_d   = wpos_q + 1'b1;
            ev       = EV_HEADER;
            if (wpos_q == LastHdrPos) begin
              if (b == 8'h00) begin
                phase_d = PhCheck;
              end else if (b > MaxLen) begin
                held_d  = 1'b0;
                phase_d = PhSearch;
                ev      = EV_LEN_BAD;
              end else begin
                remain_d = b;
                phase_d  = PhData;
              end
            end
          end
          PhData: begin
            pos      = wpos_q;
            req_o.we = 1'b1;
            crc_d    = crc8_update(crc_q, b);
            wpos_d   = wpos_q + 1'b1;
            ev       = EV_PAYLOAD;
            remain_d = remain_q - 8'd1;
            if (remain_d == 8'd0) begin
              phase_d = PhCheck;
            end
          end
          PhCheck: begin
            phase_d = PhSearch;
            if (b == crc_q) begin
              ready_mid = 1'b1;
              ev        = EV_ACCEPT;
            end else begin
              held_d = 1'b0;
              ev     = EV_CRC_BAD;
            end
          end
          default: phase_d = PhSearch;
        endcase
      end
      OP_TAKE: ;
      OP_RELEASE: held_d = 1'b0;
      OP_READ: req_o.re = 1'b1;
      OP_RESET: begin
        phase_d   = PhSearch;
        held_d    = 1'b0;
        ready_mid = 1'b0;
      end
      default: ;
    endcase

    ready_d = (item_i.opcode == OP_TAKE) ? 1'b0 : ready_mid;

    res_o.event_res     = ev;
    res_o.byte_position = pos;
    res_o.packet_ready  = ready_mid;
    res_o.buffer_held   = held_d;
    res_o.active        = held_d || ready_d || (phase_d != PhSearch && phase_d != PhSync);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSearch;
      crc_q    <= 8'h00;
      wpos_q   <= '0;
      remain_q <= 8'h00;
      held_q   <= 1'b0;
      ready_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      wpos_q   <= wpos_d;
      remain_q <= remain_d;
      held_q   <= held_d;
      ready_q  <= ready_d;
    end
  end

endmodule

// ===== design/framed_packet_receiver_crc8_core.sv =====
// Framed packet receiver top level: input register, parser, packet buffer and
// result register. Depends on fprc8_pkg, fprc8_parser and fprc8_store.
//
//   channel   direction   handshake              beat
//   input     in          in_valid_i/in_stall_o  in_item_i (in_item_t)
//   result    out         out_valid_o/out_stall_i out_item_o (out_item_t)
//
// One beat per cycle unless the result stalls; each beat gives one result.
// The parse step and CRC byte update sit between the input and result registers.
// Reset clears the parser state and both valid flags; the buffer holds no reset.
// A stalled result holds the result register; the input register then fills
// and in_stall_o rises only when both are occupied.
module framed_packet_receiver_crc8_core
  import fprc8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       in_valid_q, out_valid_q;
  in_item_t   in_q;
  parse_res_t res_d, res_q;
  store_req_t req;
  logic [7:0] rdata;
  logic       advance, fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  fprc8_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .res_o  (res_d),
    .req_o  (req)
  );

  fprc8_store u_store (
    .clk_i   (clk_i),
    .en_i    (fire),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = '{
    event_res:     res_q.event_res,
    byte_position: res_q.byte_position,
    read_data:     rdata,
    packet_ready:  res_q.packet_ready,
    buffer_held:   res_q.buffer_held,
    active:        res_q.active
  };

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side is free");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed beat left no result");

  a_accept_marks_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.event_res == EV_ACCEPT) |->
      (out_item_o.packet_ready && out_item_o.active))
    else $error("accepted packet not marked ready");

  a_drop_frees_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.event_res == EV_CRC_BAD ||
                     out_item_o.event_res == EV_LEN_BAD)) |->
      (!out_item_o.buffer_held && out_item_o.read_data == 8'h00))
    else $error("dropped packet still holds the buffer");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for framed_packet_receiver_crc8_core: directed and random byte beats with
// client opcodes, an in-bench deframer/CRC-8 predictor and a field-by-field result check.
// Depends on fprc8_pkg and the core RTL; reads no files.
module tb_top;
  import fprc8_pkg::*;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TargetBeats = 1800;

  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef enum logic [2:0] {
    HUNT_PRE,
    HUNT_SYNC,
    TAKE_HDR,
    TAKE_DATA,
    TAKE_CRC
  } rx_phase_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  rx_phase_e  phase       = HUNT_PRE;
  logic [7:0] rx_crc      = '0;
  logic [3:0] wr_pos      = '0;
  logic [7:0] bytes_left  = '0;
  logic       buf_held    = 1'b0;
  logic       rdy_flag    = 1'b0;
  logic [7:0] pkt_store [16];
  logic [15:0] pkt_written = '0;

  out_item_t results_due[$];
  out_item_t want;
  int        errors      = 0;
  int        beats_sent  = 0;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  bit        in_burst    = 1'b0;
  bit        out_burst   = 1'b0;

  framed_packet_receiver_crc8_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic void store_rx_byte(logic [7:0] b);
    rx_crc              = crc8_next(rx_crc, b);
    pkt_store[wr_pos]   = b;
    pkt_written[wr_pos] = 1'b1;
    wr_pos              = wr_pos + 4'd1;
  endfunction

  function automatic out_item_t predict_result(in_item_t beat);
    out_item_t  r;
    logic [7:0] b;
    r = '0;
    b = beat.data_byte;
    case (beat.opcode)
      OP_RX: begin
        case (phase)
          HUNT_PRE: begin
            if (b == PreambleByte) begin
              phase       = HUNT_SYNC;
              r.event_res = EV_PREAMBLE;
            end
          end
          HUNT_SYNC: begin
            if (b == SyncByte) begin
              if (!buf_held) begin
                buf_held = 1'b1;
                phase    = TAKE_HDR;
                wr_pos   = '0;
                rx_crc   = '0;
              end else begin
                phase       = HUNT_PRE;
                r.event_res = EV_BUSY;
              end
            end else if (b == PreambleByte) begin
              r.event_res = EV_PREAMBLE;
            end else begin
              phase = HUNT_PRE;
            end
          end
          TAKE_HDR: begin
            r.byte_position = wr_pos;
            store_rx_byte(b);
            r.event_res = EV_HEADER;
            if (wr_pos == HeaderBytes) begin
              if (pkt_store[3] == 8'd0) begin
                phase = TAKE_CRC;
              end else if (pkt_store[3] > MaxPayload) begin
                buf_held    = 1'b0;
                phase       = HUNT_PRE;
                r.event_res = EV_LEN_BAD;
              end else begin
                bytes_left = pkt_store[3];
                phase      = TAKE_DATA;
              end
            end
          end
          TAKE_DATA: begin
            r.byte_position = wr_pos;
            store_rx_byte(b);
            r.event_res = EV_PAYLOAD;
            bytes_left  = bytes_left - 8'd1;
            if (bytes_left == 8'd0) phase = TAKE_CRC;
          end
          TAKE_CRC: begin
            phase = HUNT_PRE;
            if (b == rx_crc) begin
              rdy_flag    = 1'b1;
              r.event_res = EV_ACCEPT;
            end else begin
              buf_held    = 1'b0;
              r.event_res = EV_CRC_BAD;
            end
          end
          default: phase = HUNT_PRE;
        endcase
      end
      OP_RELEASE: buf_held = 1'b0;
      OP_READ:    r.read_data = pkt_store[beat.read_index];
      OP_RESET: begin
        phase    = HUNT_PRE;
        buf_held = 1'b0;
        rdy_flag = 1'b0;
      end
      default: ;
    endcase
    r.packet_ready = rdy_flag;
    if (beat.opcode == OP_TAKE) rdy_flag = 1'b0;
    r.buffer_held = buf_held;
    r.active      = buf_held || rdy_flag || (phase != HUNT_PRE && phase != HUNT_SYNC);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing expected", out_item, 0);
      end else begin
        want = results_due.pop_front();
        if (out_item.event_res !== want.event_res)
          report_mismatch("event_res", out_item.event_res, want.event_res);
        if (out_item.byte_position !== want.byte_position)
          report_mismatch("byte_position", out_item.byte_position, want.byte_position);
        if (out_item.read_data !== want.read_data)
          report_mismatch("read_data", out_item.read_data, want.read_data);
        if (out_item.packet_ready !== want.packet_ready)
          report_mismatch("packet_ready", out_item.packet_ready, want.packet_ready);
        if (out_item.buffer_held !== want.buffer_held)
          report_mismatch("buffer_held", out_item.buffer_held, want.buffer_held);
        if (out_item.active !== want.active)
          report_mismatch("active", out_item.active, want.active);
      end
      stall_left = out_burst ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [7:0] b, input logic [3:0] idx);
    int       gap;
    in_item_t beat;
    beat.opcode     = op;
    beat.data_byte  = b;
    beat.read_index = idx;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk_i); while (in_stall);
    results_due.push_back(predict_result(beat));
    beats_sent++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_beat(OP_RX, b, 4'($urandom));
  endtask

  task automatic send_read();
    logic [3:0] picks[$];
    for (int i = 0; i < 16; i++) begin
      if (pkt_written[i]) picks.push_back(4'(i));
    end
    if (picks.size() == 0) begin
      send_beat(OP_TAKE, 8'($urandom), 4'($urandom));
    end else begin
      send_beat(OP_READ, 8'($urandom), picks[$urandom_range(0, picks.size() - 1)]);
    end
  endtask

  task automatic send_client_op();
    logic [2:0] op;
    op = 3'($urandom_range(1, 7));
    if (op == OP_READ) begin
      send_read();
    end else begin
      send_beat(op, 8'($urandom), 4'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_packet();
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(MaxPayload + 1, 255));
    else len = 8'($urandom_range(0, MaxPayload));
    repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
    repeat ($urandom_range(1, 2)) send_rx(PreambleByte);
    send_rx(SyncByte);
    for (int i = 0; i < HeaderBytes; i++) begin
      b = (i == HeaderBytes - 1) ? len : 8'($urandom);
      send_rx(b);
      sum = crc8_next(sum, b);
      if ($urandom_range(0, 24) == 0) send_client_op();
    end
    if (len <= MaxPayload) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        send_rx(b);
        sum = crc8_next(sum, b);
        if ($urandom_range(0, 24) == 0) send_client_op();
      end
      b = ($urandom_range(0, 9) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      send_rx(b);
    end
    if ($urandom_range(0, 9) < 6) send_beat(OP_TAKE, 8'($urandom), 4'($urandom));
    repeat ($urandom_range(0, 2)) send_read();
    if ($urandom_range(0, 9) < 8) send_beat(OP_RELEASE, 8'($urandom), 4'($urandom));
  endtask

  task automatic test_preamble_hunt();
    send_beat(OP_TAKE, 8'h00, 4'h0);
    send_rx(8'h00);
    send_rx(PreambleByte);
    send_rx(PreambleByte);
    send_rx(8'h12);
  endtask

  task automatic test_good_packet();
    logic [7:0] sum;
    sum = '0;
    send_rx(PreambleByte);
    send_rx(SyncByte);
    send_rx(8'hFF);
    sum = crc8_next(sum, 8'hFF);
    send_rx(8'h00);
    sum = crc8_next(sum, 8'h00);
    send_rx(8'hFF);
    sum = crc8_next(sum, 8'hFF);
    send_rx(8'h00);
    sum = crc8_next(sum, 8'h00);
    send_rx(sum);
    send_beat(OP_READ, 8'h00, 4'd0);
    send_beat(OP_TAKE, 8'h00, 4'd0);
    send_rx(PreambleByte);
    send_rx(SyncByte);
    send_beat(OP_RELEASE, 8'h00, 4'd0);
  endtask

  task automatic test_length_and_opcode_errors();
    send_rx(PreambleByte);
    send_rx(SyncByte);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'(MaxPayload + 1));
    send_beat(OpSpareLo, 8'hFF, 4'hF);
    send_beat(OpSpareHi, 8'h00, 4'h0);
  endtask

  task automatic test_crc_bad_after_release();
    logic [7:0] sum;
    sum = crc8_next(crc8_next(crc8_next(crc8_next(8'h00, 8'hA5), 8'h5A), 8'h3C), 8'h00);
    send_rx(PreambleByte);
    send_rx(SyncByte);
    send_rx(8'hA5);
    send_rx(8'h5A);
    send_rx(8'h3C);
    send_rx(8'h00);
    send_beat(OP_RELEASE, 8'h00, 4'd0);
    send_rx(sum ^ 8'h01);
    send_beat(OP_RESET, 8'h00, 4'd0);
  endtask

  task automatic test_random_traffic();
    int pick;
    bit paused;
    paused = 1'b0;
    while (beats_sent < TargetBeats) begin
      in_burst  = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      pick      = $urandom_range(0, 99);
      if (pick < 75) begin
        send_random_packet();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) send_rx(8'($urandom));
          else send_client_op();
        end
      end else begin
        send_beat(OP_RESET, 8'($urandom), 4'($urandom));
      end
      if (!paused && beats_sent > TargetBeats / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preamble_hunt();
    test_good_packet();
    wait_drained();
    test_length_and_opcode_errors();
    test_crc_bad_after_release();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
